// ===== src/u2ue_pkg.sv =====
// Shared types, constants and helper function of the UTF-8 to escape converter.
package u2ue_pkg;

  localparam int CodeW = 21;

  localparam logic [6:0] ChBackslash = 7'h5C;
  localparam logic [6:0] ChLowerU    = 7'h75;

  // One unit of output work: a single character or a whole escape.
  typedef struct packed {
    logic              is_esc;
    logic [CodeW-1:0]  value;
    logic              run_end;
    logic              string_end;
  } job_t;

  // Lowercase hex digit of one nibble.
  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] wide;
    wide = {3'b000, nib};
    if (nib < 4'd10) begin
      hex_char = 7'h30 + wide;
    end else begin
      hex_char = 7'h57 + wide;
    end
  endfunction

endpackage

// ===== src/u2ue_front.sv =====
// Front end: takes input bytes, runs the UTF-8 decoder and lists the output jobs.
module u2ue_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       in_byte,
  input  logic             is_last_byte,
  input  logic             q_full,
  output logic             q_push,
  output u2ue_pkg::job_t   q_job
);
  import u2ue_pkg::*;

  // Decoder state.
  logic [7:0]       lead_held, lead_held_next;
  logic [CodeW-1:0] code_accum, code_accum_next;
  logic [2:0]       seq_length, seq_length_next;
  logic [1:0]       conts_seen, conts_seen_next;
  logic [7:0]       held_conts [2];
  logic             hold_we;

  // Jobs of the last accepted beat, handed out one per cycle while the queue is not full.
  job_t             jbuf [4];
  job_t             jobs_new [4];
  logic [2:0]       jobs_cnt;
  logic [2:0]       rem;
  logic [1:0]       idx;
  logic             accept;

  // Classification of the byte as a possible sequence start.
  logic             start_emit;
  job_t             start_job;
  logic             start_seq;
  logic [2:0]       start_len;
  logic [CodeW-1:0] start_init;
  logic             is_cont;
  logic             seq_done;
  logic [CodeW-1:0] accum_ext;
  logic [1:0]       nrep;

  assign q_push = (rem != 3'd0) && !q_full;
  assign q_job  = jbuf[idx];
  assign full   = (rem > 3'd1) || ((rem == 3'd1) && q_full);
  assign accept = push && !full;

  assign is_cont   = (in_byte[7:6] == 2'b10);
  assign accum_ext = {code_accum[CodeW-7:0], in_byte[5:0]};
  assign seq_done  = ({1'b0, conts_seen} + 3'd2) >= seq_length;

  // Start-byte decode: ASCII, lead of 2 to 4 bytes, or stray.
  always_comb begin
    start_emit = 1'b0;
    start_seq  = 1'b0;
    start_len  = 3'd0;
    start_init = '0;
    start_job  = '0;
    if (!in_byte[7]) begin
      start_emit       = 1'b1;
      start_job.value  = {{(CodeW-8){1'b0}}, in_byte};
    end else begin
      if (in_byte[7:5] == 3'b110) begin
        start_seq  = 1'b1;
        start_len  = 3'd2;
        start_init = {{(CodeW-5){1'b0}}, in_byte[4:0]};
      end else if (in_byte[7:4] == 4'b1110) begin
        start_seq  = 1'b1;
        start_len  = 3'd3;
        start_init = {{(CodeW-4){1'b0}}, in_byte[3:0]};
      end else if (in_byte[7:3] == 5'b11110) begin
        start_seq  = 1'b1;
        start_len  = 3'd4;
        start_init = {{(CodeW-3){1'b0}}, in_byte[2:0]};
      end
      // A lead that ends the string, or a stray byte, escapes alone.
      if (!start_seq || is_last_byte) begin
        start_seq        = 1'b0;
        start_emit       = 1'b1;
        start_job.is_esc = 1'b1;
        start_job.value  = {{(CodeW-8){1'b0}}, in_byte};
      end
    end
  end

  // Job list and next decoder state for the byte on the input.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      jobs_new[i] = '0;
    end
    jobs_cnt        = 3'd0;
    lead_held_next  = lead_held;
    code_accum_next = code_accum;
    seq_length_next = seq_length;
    conts_seen_next = conts_seen;
    hold_we         = 1'b0;
    nrep            = 2'd1 + conts_seen;

    // Replay of a failed sequence: lead, then each held continuation.
    if (seq_length != 3'd0 && !(is_cont && (seq_done || !is_last_byte))) begin
      jobs_new[0].is_esc = 1'b1;
      jobs_new[0].value  = {{(CodeW-8){1'b0}}, lead_held};
      jobs_new[1].is_esc = 1'b1;
      jobs_new[1].value  = {{(CodeW-8){1'b0}}, held_conts[0]};
      jobs_new[2].is_esc = 1'b1;
      jobs_new[2].value  = {{(CodeW-8){1'b0}}, held_conts[1]};
    end

    if (seq_length == 3'd0) begin
      if (start_emit) begin
        jobs_new[0] = start_job;
        jobs_cnt    = 3'd1;
      end
      if (start_seq) begin
        lead_held_next  = in_byte;
        code_accum_next = start_init;
        seq_length_next = start_len;
        conts_seen_next = 2'd0;
      end
    end else if (is_cont) begin
      if (seq_done) begin
        jobs_new[0].is_esc = 1'b1;
        jobs_new[0].value  = accum_ext;
        jobs_cnt           = 3'd1;
        lead_held_next     = '0;
        code_accum_next    = '0;
        seq_length_next    = 3'd0;
        conts_seen_next    = 2'd0;
      end else if (is_last_byte) begin
        jobs_new[nrep].is_esc = 1'b1;
        jobs_new[nrep].value  = {{(CodeW-8){1'b0}}, in_byte};
        jobs_cnt              = {1'b0, nrep} + 3'd1;
        lead_held_next        = '0;
        code_accum_next       = '0;
        seq_length_next       = 3'd0;
        conts_seen_next       = 2'd0;
      end else begin
        hold_we         = 1'b1;
        code_accum_next = accum_ext;
        conts_seen_next = conts_seen + 2'd1;
      end
    end else begin
      // Broken sequence: replay, then look at this byte afresh.
      jobs_cnt        = {1'b0, nrep};
      lead_held_next  = '0;
      code_accum_next = '0;
      seq_length_next = 3'd0;
      conts_seen_next = 2'd0;
      if (start_emit) begin
        jobs_new[nrep] = start_job;
        jobs_cnt       = {1'b0, nrep} + 3'd1;
      end
      if (start_seq) begin
        lead_held_next  = in_byte;
        code_accum_next = start_init;
        seq_length_next = start_len;
      end
    end

    // Flags ride on the last job of the beat.
    if (jobs_cnt != 3'd0) begin
      jobs_new[jobs_cnt[1:0] - 2'd1].run_end    = 1'b1;
      jobs_new[jobs_cnt[1:0] - 2'd1].string_end = is_last_byte;
    end
  end

  // Decoder state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_held  <= '0;
      code_accum <= '0;
      seq_length <= 3'd0;
      conts_seen <= 2'd0;
    end else if (accept) begin
      lead_held  <= lead_held_next;
      code_accum <= code_accum_next;
      seq_length <= seq_length_next;
      conts_seen <= conts_seen_next;
    end
  end

  // Held continuation bytes, kept for a replay.
  always_ff @(posedge clk) begin
    if (accept && hold_we) begin
      held_conts[conts_seen[0]] <= in_byte;
    end
  end

  // Job buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
      idx <= 2'd0;
    end else if (accept) begin
      rem <= jobs_cnt;
      idx <= 2'd0;
    end else if (q_push) begin
      rem <= rem - 3'd1;
      idx <= idx + 2'd1;
    end
  end

  // Job buffer payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        jbuf[i] <= jobs_new[i];
      end
    end
  end

endmodule

// ===== src/u2ue_jobq.sv =====
// Small job queue between the decoder front end and the character back end.
module u2ue_jobq #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  u2ue_pkg::job_t   wr_job,
  output logic             q_full,
  input  logic             rd,
  output logic             q_empty,
  output u2ue_pkg::job_t   rd_job
);
  import u2ue_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PtrW-1:0]  wptr;
  logic [PtrW-1:0]  rptr;
  logic [CntW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count == CntW'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_job  = mem[rptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PtrW'(DEPTH - 1)) ? '0 : wptr + PtrW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PtrW'(DEPTH - 1)) ? '0 : rptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_job;
    end
  end

endmodule

// ===== src/u2ue_back.sv =====
// Back end: expands each job into output characters, one beat per cycle while pop is high and jobs wait.
module u2ue_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  u2ue_pkg::job_t   q_job,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [6:0]       out_char,
  output logic             run_end,
  output logic             string_end
);
  import u2ue_pkg::*;

  job_t        cur;
  logic        cur_valid;
  logic [2:0]  cidx;
  logic [2:0]  ndig;
  logic [2:0]  last_idx;
  logic [2:0]  pos;
  logic [3:0]  nib;
  logic        char_last;
  logic        take;

  // Digit count and index of the final character of the current job.
  always_comb begin
    if (cur.value > 21'h0FFFFF) begin
      ndig = 3'd6;
    end else if (cur.value > 21'h00FFFF) begin
      ndig = 3'd5;
    end else begin
      ndig = 3'd4;
    end
    last_idx = cur.is_esc ? (ndig + 3'd1) : 3'd0;
    pos      = ndig + 3'd1 - cidx;
  end

  // Nibble of the hex digit being shown.
  always_comb begin
    case (pos)
      3'd0:    nib = cur.value[3:0];
      3'd1:    nib = cur.value[7:4];
      3'd2:    nib = cur.value[11:8];
      3'd3:    nib = cur.value[15:12];
      3'd4:    nib = cur.value[19:16];
      3'd5:    nib = {3'b000, cur.value[20]};
      default: nib = 4'd0;
    endcase
  end

  // Character on the output ports.
  always_comb begin
    if (!cur.is_esc) begin
      out_char = cur.value[6:0];
    end else if (cidx == 3'd0) begin
      out_char = ChBackslash;
    end else if (cidx == 3'd1) begin
      out_char = ChLowerU;
    end else begin
      out_char = hex_char(nib);
    end
  end

  assign char_last  = (cidx == last_idx);
  assign empty      = !cur_valid;
  assign run_end    = cur.run_end && char_last;
  assign string_end = cur.string_end && char_last;
  assign take       = pop && cur_valid;
  assign q_pop      = !cur_valid || (take && char_last);

  // Current job and character index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cidx      <= 3'd0;
    end else if (q_pop && !q_empty) begin
      cur_valid <= 1'b1;
      cidx      <= 3'd0;
    end else if (take && char_last) begin
      cur_valid <= 1'b0;
      cidx      <= 3'd0;
    end else if (take) begin
      cidx <= cidx + 3'd1;
    end
  end

  // Job payload.
  always_ff @(posedge clk) begin
    if (q_pop && !q_empty) begin
      cur <= q_job;
    end
  end

endmodule

// ===== src/utf8_to_unicode_escape.sv =====
// Path: a byte's first output character reaches the result ports once its job has passed
// the front-end job buffer, the job queue and the back end's current-job register.
// Throughput: one input byte per cycle while each byte gives one character and pop is held
// high; an escape gives 6 to 8 output characters, and once the job queue fills the input
// waits at the output pace. A byte that replays a broken sequence keeps the front end busy
// while its up to four jobs enter the queue.
// Reset: synchronous rst empties the job buffer, the queue and the output stage and clears
// the decoder state; no clearing pass is needed.
module utf8_to_unicode_escape #(
  parameter int QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        is_last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  out_char,
  output logic        run_end,
  output logic        string_end
);
  import u2ue_pkg::*;

  logic  q_full;
  logic  q_push;
  logic  q_empty;
  logic  q_pop;
  job_t  fe_job;
  job_t  be_job;

  u2ue_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_byte      (in_byte),
    .is_last_byte (is_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (fe_job)
  );

  u2ue_jobq #(
    .DEPTH (QDEPTH)
  ) u_jobq (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_job  (fe_job),
    .q_full  (q_full),
    .rd      (q_pop),
    .q_empty (q_empty),
    .rd_job  (be_job)
  );

  u2ue_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_job      (be_job),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_char   (out_char),
    .run_end    (run_end),
    .string_end (string_end)
  );

  // The end of a string is always also the end of its byte's run.
  a_string_end_run_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && string_end) |-> run_end)
    else $error("string_end without run_end");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result pending after reset");

  // The front end never offers a job to a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("job pushed into full queue");

endmodule
